// ===== hdl/ipv4_address_port_parser_assert.svh =====
// Assertion macros for the IPv4 address/port parser.
// No dependencies; included by the top level. Bodies are empty for synthesis.
`ifndef IPV4_ADDRESS_PORT_PARSER_ASSERT_SVH
`define IPV4_ADDRESS_PORT_PARSER_ASSERT_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define IAPP_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ipv4 parser check failed");

// antecedent implies consequent in the next cycle
`define IAPP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ipv4 parser check failed");

`else

`define IAPP_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define IAPP_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== hdl/ipv4ap_pkg.sv =====
// Package for the IPv4 address/port parser: character codes, widths, status codes.
// No dependencies.
package ipv4ap_pkg;

  localparam int CHAR_W   = 8;
  localparam int OCTET_W  = 8;
  localparam int PORT_W   = 16;
  localparam int NUM_OCT  = 4;
  localparam int TALLY_W  = 3;
  localparam int OUT_W    = 56;  // 2 + 4*8 + 16 = 50 bits, padded to whole bytes

  localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'h30;  // '0'
  localparam logic [CHAR_W-1:0]  CHAR_NINE  = 8'h39;  // '9'
  localparam logic [CHAR_W-1:0]  CHAR_DOT   = 8'h2E;  // '.'
  localparam logic [CHAR_W-1:0]  CHAR_COLON = 8'h3A;  // ':'
  localparam logic [OCTET_W-1:0] OCTET_MAX  = 8'hFF;  // octet value that fails the check
  localparam logic [TALLY_W-1:0] TALLY_MAX  = 3'd7;
  localparam logic [TALLY_W-1:0] TALLY_FULL = 3'd3;   // dots in a well-formed address

  typedef enum logic [1:0] {
    ST_VALID     = 2'd0,
    ST_INVALID   = 2'd1,
    ST_MALFORMED = 2'd2
  } status_t;

  typedef logic [OCTET_W-1:0] octet_t;

endpackage

// ===== hdl/ipv4_address_port_parser.sv =====
// IPv4 dotted-quad address and port parser, one character per cycle.
// Depends on ipv4ap_pkg and ipv4_address_port_parser_assert.svh.
//
//  channel | dir | signals                 | payload
//  --------+-----+-------------------------+---------------------------------------------
//  input   | in  | s_tvalid/s_tready       | s_tdata: character; s_tlast: last
//  result  | out | m_tvalid/m_tready       | m_tdata: status, octet_a..d, port_number
//
// One item per cycle: the parse state updates in the cycle an item is accepted; the
// character marked last loads the result register and returns the state to its start.
// A result appears in the cycle after its last item is accepted and holds until m_tready.
// s_tready stays high while the result register is empty or draining, so input
// stalls only when a result waits and m_tready is low. Reset (rst, synchronous)
// empties the result register and restores the parse state.
`include "ipv4_address_port_parser_assert.svh"

module ipv4_address_port_parser (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [ipv4ap_pkg::CHAR_W-1:0]   s_tdata,   // [7:0] character
  input  logic                            s_tlast,   // last
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [ipv4ap_pkg::OUT_W-1:0]    m_tdata    // [1:0] status, [9:2] octet_a,
                                                     // [17:10] octet_b, [25:18] octet_c,
                                                     // [33:26] octet_d, [49:34] port_number,
                                                     // [55:50] zero
);
  import ipv4ap_pkg::*;

  typedef enum logic [1:0] {
    PH_OCTET = 2'd0,
    PH_PORT  = 2'd1,
    PH_STOP  = 2'd2
  } phase_t;

  // parse state
  phase_t              phase, phase_next;
  logic                at_first, at_first_next;
  logic                bad_start, bad_start_next;
  logic [TALLY_W-1:0]  dot_tally, dot_tally_next;
  octet_t              octets [NUM_OCT];
  octet_t              octets_next [NUM_OCT];
  logic [PORT_W-1:0]   port_accum, port_accum_next;

  // result register
  status_t             res_status, status_next;
  octet_t              res_octets [NUM_OCT];
  logic [PORT_W-1:0]   res_port;

  logic                in_fire;
  logic                is_digit;
  logic [3:0]          digit;
  logic [1:0]          oct_idx;
  octet_t              oct_cur;

  assign in_fire  = s_tvalid && s_tready;
  assign s_tready = !m_tvalid || m_tready;

  assign is_digit = (s_tdata >= CHAR_ZERO) && (s_tdata <= CHAR_NINE);
  assign digit    = 4'(s_tdata - CHAR_ZERO);
  assign oct_idx  = dot_tally[1:0];
  assign oct_cur  = octets[oct_idx];

  // next parse state for the incoming character
  always_comb begin
    phase_next      = phase;
    at_first_next   = 1'b0;
    bad_start_next  = bad_start;
    dot_tally_next  = dot_tally;
    octets_next     = octets;
    port_accum_next = port_accum;
    if (at_first && !is_digit) begin
      bad_start_next = 1'b1;
      phase_next     = PH_STOP;
    end else begin
      unique case (phase)
        PH_OCTET: begin
          if (is_digit) begin
            // octets past the fourth are dropped
            if (!dot_tally[2]) begin
              octets_next[oct_idx] = {oct_cur[4:0], 3'b000} + {oct_cur[6:0], 1'b0}
                                     + {4'b0000, digit};
            end
          end else if (s_tdata == CHAR_DOT) begin
            if (dot_tally != TALLY_MAX) begin
              dot_tally_next = dot_tally + 3'd1;
            end
            if (!dot_tally_next[2]) begin
              octets_next[dot_tally_next[1:0]] = '0;
            end
          end else if (s_tdata == CHAR_COLON) begin
            phase_next = PH_PORT;
          end else begin
            phase_next = PH_STOP;
          end
        end
        PH_PORT: begin
          if (is_digit) begin
            port_accum_next = {port_accum[12:0], 3'b000} + {port_accum[14:0], 1'b0}
                              + {12'h000, digit};
          end else begin
            phase_next = PH_STOP;
          end
        end
        default: ;  // stopped: characters are ignored
      endcase
    end
  end

  // status of the string as it stands after this character
  always_comb begin
    if (bad_start_next) begin
      status_next = ST_MALFORMED;
    end else if ((dot_tally_next == TALLY_FULL)
                 && (octets_next[0] != OCTET_MAX) && (octets_next[1] != OCTET_MAX)
                 && (octets_next[2] != OCTET_MAX) && (octets_next[3] != OCTET_MAX)) begin
      status_next = ST_VALID;
    end else begin
      status_next = ST_INVALID;
    end
  end

  // parse state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_OCTET;
      at_first   <= 1'b1;
      bad_start  <= 1'b0;
      dot_tally  <= '0;
      octets     <= '{default: '0};
      port_accum <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (in_fire) begin
        if (s_tlast) begin
          phase      <= PH_OCTET;
          at_first   <= 1'b1;
          bad_start  <= 1'b0;
          dot_tally  <= '0;
          octets     <= '{default: '0};
          port_accum <= '0;
        end else begin
          phase      <= phase_next;
          at_first   <= at_first_next;
          bad_start  <= bad_start_next;
          dot_tally  <= dot_tally_next;
          octets     <= octets_next;
          port_accum <= port_accum_next;
        end
      end
      if (in_fire && s_tlast) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_fire && s_tlast) begin
      res_status <= status_next;
      res_octets <= octets_next;
      res_port   <= port_accum_next;
    end
  end

  assign m_tdata = {6'b000000, res_port, res_octets[3], res_octets[2], res_octets[1],
                    res_octets[0], res_status};

  // checks
  `IAPP_ASSERT_NEXT(a_last_gives_result, clk, rst, in_fire && s_tlast, m_tvalid)
  `IAPP_ASSERT_NEXT(a_last_restarts, clk, rst, in_fire && s_tlast,
                    at_first && !bad_start && (dot_tally == '0) && (phase == PH_OCTET))
  `IAPP_ASSERT_SAME(a_malformed_zero, clk, rst, m_tvalid && (res_status == ST_MALFORMED),
                    (res_port == '0) && (res_octets[0] == '0) && (res_octets[3] == '0))
  `IAPP_ASSERT_SAME(a_first_state, clk, rst, at_first,
                    !bad_start && (dot_tally == '0) && (port_accum == '0))

endmodule

// ===== dv/ipv4_address_port_parser_test.sv =====
// Self-checking testbench for the dotted-quad IPv4 address and port parser.
// Drives character strings on the input stream, predicts each parse result and checks it.
// Depends on ipv4ap_pkg and the ipv4_address_port_parser top level.
`timescale 1ns / 1ps

module ipv4_address_port_parser_test;
  import ipv4ap_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned RAND_CHARS   = 1400;
  localparam int unsigned MAX_REPORTS  = 10;

  // parse phase of the predictor
  typedef enum logic [1:0] {
    PH_OCTETS = 2'd0,
    PH_PORT   = 2'd1,
    PH_HALTED = 2'd2
  } parse_phase_t;

  // one character on the input stream
  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic              drain_first;  // wait for all results before sending
  } char_item_t;

  // result layout, status in the lowest bits
  typedef struct packed {
    logic [PORT_W-1:0] port;
    octet_t            oct_d;
    octet_t            oct_c;
    octet_t            oct_b;
    octet_t            oct_a;
    status_t           status;
  } addr_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [CHAR_W-1:0]   s_tdata = '0;
  logic                s_tlast = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OUT_W-1:0]    m_tdata;

  char_item_t          char_q[$];
  addr_result_t        addr_q[$];
  logic [CHAR_W-1:0]   text_buf[$];

  // predictor state
  parse_phase_t        ph;
  logic                at_first;
  logic                bad_first;
  logic [TALLY_W-1:0]  dots;
  octet_t              oct_acc[NUM_OCT];
  logic [PORT_W-1:0]   port_acc;

  int unsigned         err_cnt = 0;
  int unsigned         cycle_cnt = 0;
  int unsigned         send_gap = 0;
  int unsigned         ready_gap = 0;
  int unsigned         text_cnt = 0;
  logic                in_taken = 1'b0;
  logic                quiet;

  ipv4_address_port_parser uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // stretches with no idling on either side
  assign quiet = (cycle_cnt[9:8] == 2'b11);

  // idle length: mostly none or short, now and then long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  task automatic clear_parse();
    ph        = PH_OCTETS;
    at_first  = 1'b1;
    bad_first = 1'b0;
    dots      = '0;
    port_acc  = '0;
    for (int i = 0; i < NUM_OCT; i++) oct_acc[i] = '0;
  endtask

  // advance the predicted parse by one character, queue a result on last
  task automatic parse_char(input logic [CHAR_W-1:0] c, input logic lst);
    logic              dig;
    logic              halted_now;
    logic [15:0]       oct_next;
    logic [31:0]       port_next;
    logic              range_ok;
    addr_result_t      res;
    dig = is_digit(c);
    halted_now = 1'b0;
    if (at_first) begin
      at_first = 1'b0;
      if (!dig) begin
        bad_first  = 1'b1;
        ph         = PH_HALTED;
        halted_now = 1'b1;
      end
    end
    if (!halted_now) begin
      case (ph)
        PH_OCTETS: begin
          if (dig) begin
            // digits past the fourth octet are dropped
            if (dots <= TALLY_FULL) begin
              oct_next = {8'd0, oct_acc[dots]} * 16'd10 + {8'd0, c - CHAR_ZERO};
              oct_acc[dots] = oct_next[7:0];
            end
          end else if (c == CHAR_DOT) begin
            if (dots < TALLY_MAX) dots = dots + 1'b1;
            if (dots <= TALLY_FULL) oct_acc[dots] = '0;
          end else if (c == CHAR_COLON) begin
            ph = PH_PORT;
          end else begin
            ph = PH_HALTED;
          end
        end
        PH_PORT: begin
          if (dig) begin
            port_next = {16'd0, port_acc} * 32'd10 + {24'd0, c - CHAR_ZERO};
            port_acc = port_next[15:0];
          end else begin
            ph = PH_HALTED;
          end
        end
        default: ;
      endcase
    end
    if (lst) begin
      range_ok = 1'b1;
      for (int i = 0; i < NUM_OCT; i++)
        if (oct_acc[i] >= OCTET_MAX) range_ok = 1'b0;
      if (bad_first) res.status = ST_MALFORMED;
      else if (dots == TALLY_FULL && range_ok) res.status = ST_VALID;
      else res.status = ST_INVALID;
      res.oct_a = oct_acc[0];
      res.oct_b = oct_acc[1];
      res.oct_c = oct_acc[2];
      res.oct_d = oct_acc[3];
      res.port  = port_acc;
      addr_q.push_back(res);
      clear_parse();
    end
  endtask

  task automatic log_error(input string msg);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // predict on accepted input items, check accepted result items
  always @(posedge clk) begin
    addr_result_t exp_res;
    addr_result_t got_res;
    if (rst) begin
      in_taken = 1'b0;
      clear_parse();
    end else begin
      in_taken = s_tvalid && s_tready;
      if (in_taken) parse_char(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        got_res = addr_result_t'(m_tdata[49:0]);
        if (addr_q.size() == 0) begin
          log_error($sformatf("result item with nothing expected: %h", m_tdata));
        end else begin
          exp_res = addr_q.pop_front();
          if (got_res.status !== exp_res.status || got_res.oct_a !== exp_res.oct_a ||
              got_res.oct_b !== exp_res.oct_b || got_res.oct_c !== exp_res.oct_c ||
              got_res.oct_d !== exp_res.oct_d || got_res.port !== exp_res.port ||
              m_tdata[OUT_W-1:50] !== '0)
            log_error($sformatf({"exp st=%0d %0d.%0d.%0d.%0d:%0d pad=0, ",
                                 "got st=%0d %0d.%0d.%0d.%0d:%0d pad=%0d"},
                                exp_res.status, exp_res.oct_a, exp_res.oct_b,
                                exp_res.oct_c, exp_res.oct_d, exp_res.port,
                                got_res.status, got_res.oct_a, got_res.oct_b,
                                got_res.oct_c, got_res.oct_d, got_res.port,
                                m_tdata[OUT_W-1:50]));
        end
      end
    end
  end

  // input driver: next item at the falling edge once the current one is taken
  always @(negedge clk) begin
    char_item_t item;
    if (!rst && (!s_tvalid || in_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (char_q.size() > 0 && !(char_q[0].drain_first && addr_q.size() != 0)) begin
        item = char_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= item.ch;
        s_tlast  <= item.last;
        send_gap = quiet ? 0 : idle_len();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result sink with random stalls
  always @(negedge clk) begin
    if (!rst) begin
      if (ready_gap > 0) begin
        ready_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        ready_gap = quiet ? 0 : idle_len();
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---- stimulus building ----

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endtask

  task automatic add_number(input int unsigned val, input int unsigned lead);
    logic [CHAR_W-1:0] digs[$];
    int unsigned       v;
    v = val;
    if (v == 0) digs.push_back(CHAR_ZERO);
    while (v > 0) begin
      digs.push_front(CHAR_ZERO + CHAR_W'(v % 10));
      v = v / 10;
    end
    repeat (lead) text_buf.push_back(CHAR_ZERO);
    foreach (digs[i]) text_buf.push_back(digs[i]);
  endtask

  // turn the text buffer into one string of input items
  task automatic flush_text(input logic drain_first);
    char_item_t item;
    foreach (text_buf[i]) begin
      item.ch          = text_buf[i];
      item.last        = (i == text_buf.size() - 1);
      item.drain_first = drain_first && (i == 0);
      char_q.push_back(item);
    end
    text_cnt += text_buf.size();
    text_buf.delete();
  endtask

  task automatic add_junk(input int unsigned n);
    repeat (n) text_buf.push_back(CHAR_W'($urandom_range(0, 255)));
  endtask

  // mostly well-formed address strings with random content
  task automatic add_random_address();
    int unsigned n_oct;
    int unsigned r;
    n_oct = ($urandom_range(0, 9) < 8) ? NUM_OCT : $urandom_range(1, 8);
    for (int i = 0; i < n_oct; i++) begin
      if (i > 0) text_buf.push_back(CHAR_DOT);
      r = $urandom_range(0, 99);
      if (r < 65) add_number($urandom_range(0, 254), ($urandom_range(0, 9) == 0));
      else if (r < 78) add_number(255, 0);
      else if (r < 90) add_number($urandom_range(256, 999), 0);
      else if (r < 95) add_number($urandom_range(0, 9), 0);
      else text_buf.push_back(CHAR_DOT);
    end
    if ($urandom_range(0, 1) == 1) begin
      text_buf.push_back(CHAR_COLON);
      r = $urandom_range(0, 9);
      if (r < 6) add_number($urandom_range(0, 65535), 0);
      else if (r < 8) add_number($urandom_range(65536, 999999), 0);
      else if (r < 9) add_number($urandom_range(0, 99), $urandom_range(0, 2));
    end
    // optional terminator with ignored trailing characters, or raw trailing bytes
    case ($urandom_range(0, 3))
      1: begin
        text_buf.push_back('0);
        add_junk($urandom_range(0, 3));
      end
      2: add_junk($urandom_range(1, 4));
      default: ;
    endcase
  endtask

  // broken strings: any mix of digits, separators and raw bytes
  task automatic add_noise();
    int unsigned len;
    int unsigned r;
    len = $urandom_range(1, 12);
    repeat (len) begin
      r = $urandom_range(0, 9);
      if (r < 4) text_buf.push_back(CHAR_ZERO + CHAR_W'($urandom_range(0, 9)));
      else if (r < 6) text_buf.push_back(CHAR_DOT);
      else if (r < 7) text_buf.push_back(CHAR_COLON);
      else text_buf.push_back(CHAR_W'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int unsigned n_str;
    // NUL as the only character: malformed start
    text_buf.push_back('0);
    flush_text(1'b0);
    // all-ones byte as the only character: malformed start
    text_buf.push_back(8'hFF);
    flush_text(1'b0);
    // single digit marked last, no dots
    add_text("7");
    flush_text(1'b0);
    // plain valid address, sent only after everything before has drained
    add_text("1.2.3.4");
    flush_text(1'b1);
    // octet wrap, empty octets, port, then a stop character
    add_text("256.1..:9x");
    flush_text(1'b0);
    // octet at the limit and dot count saturating
    add_text("255........");
    flush_text(1'b0);

    n_str = 0;
    text_cnt = 0;
    while (text_cnt < RAND_CHARS) begin
      if ($urandom_range(0, 9) < 7) add_random_address();
      else add_noise();
      n_str++;
      flush_text((n_str % 40) == 0);
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (char_q.size() != 0 || s_tvalid || addr_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0 && addr_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/ipv4ap_pkg.sv
hdl/ipv4_address_port_parser.sv
dv/ipv4_address_port_parser_test.sv
